[src/tccc_pkg.sv]
// Shared types and constants for the text console cursor controller.
// Used by every module under src; no dependencies of its own.
`default_nettype none
package tccc_pkg;

  localparam int unsigned GLYPH_WIDTH  = 8;
  localparam int unsigned GLYPH_HEIGHT = 16;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] TAB_MASK = 8'h07;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BPP       = 3'd4;

  localparam logic [7:0]  RST_COLUMNS = 8'd80;
  localparam logic [7:0]  RST_ROWS    = 8'd30;
  localparam logic [31:0] RST_BASE    = 32'd0;
  localparam logic [15:0] RST_PITCH   = 16'd1280;
  localparam logic [2:0]  RST_BPP     = 3'd2;

  typedef enum logic [1:0] {
    CMD_DRAW   = 2'd0,
    CMD_SCROLL = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_BS,
    OP_TAB,
    OP_LF,
    OP_VT,
    OP_FF,
    OP_DEL,
    OP_PRINT
  } op_e;

  typedef struct packed {
    op_e        kind;
    logic [7:0] glyph;
  } op_t;

  typedef struct packed {
    logic [7:0]  columns;
    logic [7:0]  rows;
    logic [31:0] screen_base;
    logic [15:0] line_pitch;
    logic [2:0]  bytes_per_pixel;
  } cfg_t;

  typedef struct packed {
    cmd_e        command;
    logic [7:0]  glyph;
    logic [7:0]  column;
    logic [7:0]  row;
    logic [31:0] address;
    logic        last;
  } cmd_t;

endpackage
`default_nettype wire

[src/tccc_front.sv]
// Front end: accepts character bytes and classifies them into operations.
// Depends on tccc_pkg; feeds tccc_queue.
`default_nettype none
module tccc_front (
  input  wire logic         in_valid_i,
  input  wire logic [7:0]   char_byte_i,
  input  wire logic         q_full_i,
  output logic              in_ready_o,
  output logic              push_o,
  output tccc_pkg::op_t     entry_o
);

  tccc_pkg::op_e kind;

  always_comb begin
    case (char_byte_i)
      tccc_pkg::CH_NUL, tccc_pkg::CH_CR: kind = tccc_pkg::OP_NONE;
      tccc_pkg::CH_BS:                   kind = tccc_pkg::OP_BS;
      tccc_pkg::CH_TAB:                  kind = tccc_pkg::OP_TAB;
      tccc_pkg::CH_LF:                   kind = tccc_pkg::OP_LF;
      tccc_pkg::CH_VT:                   kind = tccc_pkg::OP_VT;
      tccc_pkg::CH_FF:                   kind = tccc_pkg::OP_FF;
      tccc_pkg::CH_DEL:                  kind = tccc_pkg::OP_DEL;
      default:                           kind = tccc_pkg::OP_PRINT;
    endcase
  end

  assign in_ready_o    = !q_full_i;
  assign push_o        = in_valid_i && !q_full_i;
  assign entry_o.kind  = kind;
  assign entry_o.glyph = (kind == tccc_pkg::OP_DEL) ? tccc_pkg::CH_SPACE : char_byte_i;

endmodule
`default_nettype wire

[src/tccc_queue.sv]
// Short queue of classified operations between front and back end.
// Depends on tccc_pkg.
`default_nettype none
module tccc_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  tccc_pkg::op_t      entry_i,
  input  wire logic          pop_i,
  output logic               full_o,
  output logic               valid_o,
  output tccc_pkg::op_t      entry_o
);

  localparam logic [tccc_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
    tccc_pkg::QUEUE_PTR_W'(tccc_pkg::QUEUE_DEPTH - 1);
  localparam logic [tccc_pkg::QUEUE_PTR_W-1:0] ONE_PTR =
    tccc_pkg::QUEUE_PTR_W'(1);
  localparam logic [tccc_pkg::QUEUE_CNT_W-1:0] FULL_CNT =
    tccc_pkg::QUEUE_CNT_W'(tccc_pkg::QUEUE_DEPTH);
  localparam logic [tccc_pkg::QUEUE_CNT_W-1:0] ONE_CNT =
    tccc_pkg::QUEUE_CNT_W'(1);

  tccc_pkg::op_t                      mem_q [tccc_pkg::QUEUE_DEPTH];
  logic [tccc_pkg::QUEUE_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [tccc_pkg::QUEUE_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [tccc_pkg::QUEUE_CNT_W-1:0]   count_q, count_d;
  logic                               do_push, do_pop;

  assign full_o  = (count_q == FULL_CNT);
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + ONE_PTR;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + ONE_PTR;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + ONE_CNT;
    end else if (do_pop && !do_push) begin
      count_d = count_q - ONE_CNT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule
`default_nettype wire

[src/tccc_back.sv]
// Back end: keeps the cursor, executes operations and buffers the commands.
// Depends on tccc_pkg; reads from tccc_queue.
`default_nettype none
module tccc_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  tccc_pkg::cfg_t     cfg_i,
  input  wire logic          q_valid_i,
  input  tccc_pkg::op_t      q_entry_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output tccc_pkg::cmd_t     out_cmd_o
);

  logic [7:0]      col_q, col_d, row_q, row_d;
  tccc_pkg::cmd_t  slot0_q, slot1_q;
  logic            v0_q, v1_q;

  logic            take, exec;
  logic [8:0]      col_inc, row_inc, tab_next;
  logic            wrap_adv, wrap_tab, nl_scroll;
  logic [7:0]      sb_col, sb_row, draw_col, draw_row;
  logic [23:0]     row_pitch;
  logic [10:0]     col_bpp;
  logic [31:0]     draw_addr;
  tccc_pkg::cmd_t  first, second;
  logic            has_first, has_second;

  assign col_inc   = {1'b0, col_q} + 9'd1;
  assign row_inc   = {1'b0, row_q} + 9'd1;
  assign tab_next  = {1'b0, col_q | tccc_pkg::TAB_MASK} + 9'd1;
  assign wrap_adv  = (col_inc >= {1'b0, cfg_i.columns});
  assign wrap_tab  = (tab_next >= {1'b0, cfg_i.columns});
  assign nl_scroll = !(row_inc < {1'b0, cfg_i.rows});

  always_comb begin
    sb_col = col_q;
    sb_row = row_q;
    if (col_q == '0) begin
      if (row_q != '0) begin
        sb_col = cfg_i.columns - 8'd1;
        sb_row = row_q - 8'd1;
      end
    end else begin
      sb_col = col_q - 8'd1;
    end
  end

  assign draw_col  = (q_entry_i.kind == tccc_pkg::OP_DEL) ? sb_col : col_q;
  assign draw_row  = (q_entry_i.kind == tccc_pkg::OP_DEL) ? sb_row : row_q;
  assign row_pitch = {16'd0, draw_row} * {8'd0, cfg_i.line_pitch};
  assign col_bpp   = {3'd0, draw_col} * {8'd0, cfg_i.bytes_per_pixel};
  assign draw_addr = cfg_i.screen_base
                   + 32'(32'(row_pitch) * tccc_pkg::GLYPH_HEIGHT)
                   + 32'(32'(col_bpp) * tccc_pkg::GLYPH_WIDTH);

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    has_first  = 1'b0;
    has_second = 1'b0;
    first      = '{command: tccc_pkg::CMD_SCROLL, glyph: 8'd0, column: 8'd0,
                   row: 8'd0, address: cfg_i.screen_base, last: 1'b1};
    second     = first;
    case (q_entry_i.kind)
      tccc_pkg::OP_BS: begin
        col_d = sb_col;
        row_d = sb_row;
      end
      tccc_pkg::OP_TAB: begin
        if (wrap_tab) begin
          col_d     = '0;
          has_first = nl_scroll;
          if (!nl_scroll) begin
            row_d = row_inc[7:0];
          end
        end else begin
          col_d = tab_next[7:0];
        end
      end
      tccc_pkg::OP_LF, tccc_pkg::OP_VT: begin
        if (q_entry_i.kind == tccc_pkg::OP_LF) begin
          col_d = '0;
        end
        has_first = nl_scroll;
        if (!nl_scroll) begin
          row_d = row_inc[7:0];
        end
      end
      tccc_pkg::OP_FF: begin
        col_d         = '0;
        row_d         = '0;
        has_first     = 1'b1;
        first.command = tccc_pkg::CMD_CLEAR;
      end
      tccc_pkg::OP_DEL: begin
        col_d         = sb_col;
        row_d         = sb_row;
        has_first     = 1'b1;
        first.command = tccc_pkg::CMD_DRAW;
        first.glyph   = q_entry_i.glyph;
        first.column  = draw_col;
        first.row     = draw_row;
        first.address = draw_addr;
      end
      tccc_pkg::OP_PRINT: begin
        has_first     = 1'b1;
        first.command = tccc_pkg::CMD_DRAW;
        first.glyph   = q_entry_i.glyph;
        first.column  = draw_col;
        first.row     = draw_row;
        first.address = draw_addr;
        if (wrap_adv) begin
          col_d      = '0;
          has_second = nl_scroll;
          first.last = !nl_scroll;
          if (!nl_scroll) begin
            row_d = row_inc[7:0];
          end
        end else begin
          col_d = col_inc[7:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign take        = v0_q && out_ready_i;
  assign exec        = q_valid_i && (!v0_q || (out_ready_i && !v1_q));
  assign pop_o       = exec;
  assign out_valid_o = v0_q;
  assign out_cmd_o   = slot0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      v0_q  <= 1'b0;
      v1_q  <= 1'b0;
    end else begin
      if (exec) begin
        col_q <= col_d;
        row_q <= row_d;
        v0_q  <= has_first;
        v1_q  <= has_second;
      end else if (take) begin
        v0_q <= v1_q;
        v1_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      slot0_q <= first;
      slot1_q <= second;
    end else if (take) begin
      slot0_q <= slot1_q;
    end
  end

endmodule
`default_nettype wire

[src/text_console_cursor_controller.sv]
// Text console cursor controller: top level with the configuration registers.
// Depends on tccc_pkg, tccc_front, tccc_queue and tccc_back.
//
// Usage: character bytes enter on the in channel (in_valid_i/in_ready_o,
// char_byte_i). Display commands leave on the out channel (out_valid_o/
// out_ready_i) with command, glyph, cell column/row, byte address and a last
// flag on the final command of each character. Registers are written over
// the cfg channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i); the
// port is always ready and writes land on the next edge.
// A byte accepted on the in channel is registered in the queue and then
// executed by the back. The front takes one byte per cycle while the
// two-entry queue has room; the back executes one byte per cycle while its
// output buffer can drain and holds up to two commands, so a byte that
// causes a draw and a scroll fills both. Bytes with no command emit none.
// Reset clears the cursor to (0,0), empties queue and output buffer and
// loads the default geometry. When the receiver stalls, the output command
// holds, the back stops, then the queue fills and in_ready_o drops.
`default_nettype none
module text_console_cursor_controller (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  char_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       command_o,
  output logic [7:0]       glyph_code_o,
  output logic [7:0]       cell_column_o,
  output logic [7:0]       cell_row_o,
  output logic [31:0]      cell_address_o,
  output logic             last_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [tccc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  tccc_pkg::cfg_t  cfg_q, cfg_d;
  tccc_pkg::op_t   push_entry, head_entry;
  tccc_pkg::cmd_t  out_cmd;
  logic            push, pop, q_full, q_valid;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        tccc_pkg::REG_COLUMNS: cfg_d.columns         = cfg_data_i[7:0];
        tccc_pkg::REG_ROWS:    cfg_d.rows            = cfg_data_i[7:0];
        tccc_pkg::REG_BASE:    cfg_d.screen_base     = cfg_data_i;
        tccc_pkg::REG_PITCH:   cfg_d.line_pitch      = cfg_data_i[15:0];
        tccc_pkg::REG_BPP:     cfg_d.bytes_per_pixel = cfg_data_i[2:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.columns         <= tccc_pkg::RST_COLUMNS;
      cfg_q.rows            <= tccc_pkg::RST_ROWS;
      cfg_q.screen_base     <= tccc_pkg::RST_BASE;
      cfg_q.line_pitch      <= tccc_pkg::RST_PITCH;
      cfg_q.bytes_per_pixel <= tccc_pkg::RST_BPP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tccc_front u_front (
    .in_valid_i  (in_valid_i),
    .char_byte_i (char_byte_i),
    .q_full_i    (q_full),
    .in_ready_o  (in_ready_o),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  tccc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  tccc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_entry_i   (head_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_cmd_o   (out_cmd)
  );

  assign command_o      = out_cmd.command;
  assign glyph_code_o   = out_cmd.glyph;
  assign cell_column_o  = out_cmd.column;
  assign cell_row_o     = out_cmd.row;
  assign cell_address_o = out_cmd.address;
  assign last_o         = out_cmd.last;

endmodule
`default_nettype wire
